// ----- rtl/core/mpct_pkg.sv -----
package mpct_pkg;

  // Cursor coordinate width
  localparam int POS_BITS = 14;
  // Width of the bound registers
  localparam int LIM_W = 15;
  // Working width for the clamp compare
  localparam int CLAMP_W = ((LIM_W > POS_BITS + 1) ? LIM_W : POS_BITS + 1) + 1;

  // Packet queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Reset cursor position and bounds
  localparam logic [POS_BITS-1:0] CURSOR_X_RST = POS_BITS'(160);
  localparam logic [POS_BITS-1:0] CURSOR_Y_RST = POS_BITS'(100);
  localparam logic [LIM_W-1:0] WIDTH_RST = LIM_W'(320);
  localparam logic [LIM_W-1:0] HEIGHT_RST = LIM_W'(200);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT = 1'b1;

  // Input item kinds
  localparam logic FUNC_RX_BYTE = 1'b0;
  localparam logic FUNC_SET_POS = 1'b1;

  // Header byte fields
  localparam int HDR_X_SIGN = 4;
  localparam int HDR_Y_SIGN = 5;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XBYTE  = 2'd1,
    PH_YBYTE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_MOVE  = 2'd0,
    EV_DOWN  = 2'd1,
    EV_UP    = 2'd2,
    EV_CLICK = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_LEFT  = 2'd1,
    BTN_RIGHT = 2'd2
  } btn_t;

  // Pending event bits of one packet, in emission order
  localparam int EV_N = 7;
  localparam int EV_IDX_W = $clog2(EV_N);
  localparam int EVB_MOVE   = 0;
  localparam int EVB_LDOWN  = 1;
  localparam int EVB_LUP    = 2;
  localparam int EVB_LCLICK = 3;
  localparam int EVB_RDOWN  = 4;
  localparam int EVB_RUP    = 5;
  localparam int EVB_RCLICK = 6;

  // One decoded packet, queued between front and back
  typedef struct packed {
    logic [POS_BITS-1:0] pos_x;
    logic [POS_BITS-1:0] pos_y;
    logic [2:0]          buttons;
    logic [EV_N-1:0]     ev_mask;
  } pkt_t;

  // Event kind for a pending-event bit
  function automatic ev_kind_t ev_kind(input logic [EV_IDX_W-1:0] idx);
    ev_kind_t k;
    unique case (idx)
      EV_IDX_W'(EVB_LDOWN), EV_IDX_W'(EVB_RDOWN):   k = EV_DOWN;
      EV_IDX_W'(EVB_LUP), EV_IDX_W'(EVB_RUP):       k = EV_UP;
      EV_IDX_W'(EVB_LCLICK), EV_IDX_W'(EVB_RCLICK): k = EV_CLICK;
      default:                                      k = EV_MOVE;
    endcase
    return k;
  endfunction

  // Button for a pending-event bit
  function automatic btn_t ev_button(input logic [EV_IDX_W-1:0] idx);
    btn_t b;
    unique case (idx)
      EV_IDX_W'(EVB_LDOWN), EV_IDX_W'(EVB_LUP), EV_IDX_W'(EVB_LCLICK): b = BTN_LEFT;
      EV_IDX_W'(EVB_RDOWN), EV_IDX_W'(EVB_RUP), EV_IDX_W'(EVB_RCLICK): b = BTN_RIGHT;
      default:                                                         b = BTN_NONE;
    endcase
    return b;
  endfunction

  // Clamp a moved coordinate into [0, bound-1]; a zero bound acts as one and
  // the bound saturates at the coordinate range.
  function automatic logic [POS_BITS-1:0] clamp_coord(
    input logic signed [POS_BITS+1:0] v,
    input logic [LIM_W-1:0]           limit
  );
    logic [CLAMP_W-1:0]  eff;
    logic [CLAMP_W-1:0]  top;
    logic [POS_BITS-1:0] r;
    eff = CLAMP_W'(limit);
    if (eff == '0) eff = CLAMP_W'(1);
    if (eff > CLAMP_W'(2**POS_BITS)) eff = CLAMP_W'(2**POS_BITS);
    top = eff - CLAMP_W'(1);
    if (v[POS_BITS+1]) begin
      r = '0;
    end else if (CLAMP_W'(v[POS_BITS:0]) > top) begin
      r = top[POS_BITS-1:0];
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mpct_in_if.sv -----
interface mpct_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [7:0]                    rx_byte;
  logic [mpct_pkg::POS_BITS-1:0] new_x;
  logic [mpct_pkg::POS_BITS-1:0] new_y;

  modport source (output valid, func, rx_byte, new_x, new_y, input ready);
  modport sink (input valid, func, rx_byte, new_x, new_y, output ready);
endinterface

// ----- rtl/core/mpct_out_if.sv -----
interface mpct_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_kind;
  logic [mpct_pkg::POS_BITS-1:0] pos_x;
  logic [mpct_pkg::POS_BITS-1:0] pos_y;
  logic [1:0]                    which_button;
  logic [2:0]                    button_bits;
  logic                          last;

  modport source (output valid, event_kind, pos_x, pos_y, which_button, button_bits, last,
                  input ready);
  modport sink (input valid, event_kind, pos_x, pos_y, which_button, button_bits, last,
                output ready);
endinterface

// ----- rtl/core/mpct_front.sv -----
module mpct_front (
  input  logic                          clk,
  input  logic                          rst,
  mpct_in_if.sink                       mouse,
  input  logic [mpct_pkg::LIM_W-1:0]    width_limit,
  input  logic [mpct_pkg::LIM_W-1:0]    height_limit,
  input  logic                          q_full,
  output logic                          push,
  output mpct_pkg::pkt_t                pkt
);

  mpct_pkg::phase_t              phase, phase_next;
  logic [7:0]                    header_byte;
  logic [7:0]                    x_move_byte;
  logic [mpct_pkg::POS_BITS-1:0] cursor_x;
  logic [mpct_pkg::POS_BITS-1:0] cursor_y;
  logic [2:0]                    buttons_now;

  logic                                 accept;
  logic                                 take_byte;
  logic                                 last_byte;
  logic signed [8:0]                    dx9;
  logic signed [8:0]                    dy9;
  logic signed [mpct_pkg::POS_BITS+1:0] sum_x;
  logic signed [mpct_pkg::POS_BITS+1:0] sum_y;
  logic [2:0]                           changed;

  // Every item is taken while the packet queue has room
  assign mouse.ready = !q_full;
  assign accept      = mouse.valid && mouse.ready;
  assign take_byte   = accept && (mouse.func == mpct_pkg::FUNC_RX_BYTE);
  assign last_byte   = take_byte && (phase == mpct_pkg::PH_YBYTE);

  // 9-bit deltas from the header sign bits
  assign dx9 = {header_byte[mpct_pkg::HDR_X_SIGN], x_move_byte};
  assign dy9 = {header_byte[mpct_pkg::HDR_Y_SIGN], mouse.rx_byte};

  // Screen y grows downward, so the y delta is subtracted
  assign sum_x = $signed({2'b00, cursor_x}) + (mpct_pkg::POS_BITS+2)'(dx9);
  assign sum_y = $signed({2'b00, cursor_y}) - (mpct_pkg::POS_BITS+2)'(dy9);

  // Decoded packet with its event list
  always_comb begin
    pkt.pos_x   = mpct_pkg::clamp_coord(sum_x, width_limit);
    pkt.pos_y   = mpct_pkg::clamp_coord(sum_y, height_limit);
    pkt.buttons = header_byte[2:0];
    changed     = header_byte[2:0] ^ buttons_now;
    pkt.ev_mask = '0;
    pkt.ev_mask[mpct_pkg::EVB_MOVE]   = (dx9 != '0) || (dy9 != '0);
    pkt.ev_mask[mpct_pkg::EVB_LDOWN]  = changed[0] && header_byte[0];
    pkt.ev_mask[mpct_pkg::EVB_LUP]    = changed[0] && !header_byte[0];
    pkt.ev_mask[mpct_pkg::EVB_LCLICK] = changed[0] && !header_byte[0];
    pkt.ev_mask[mpct_pkg::EVB_RDOWN]  = changed[1] && header_byte[1];
    pkt.ev_mask[mpct_pkg::EVB_RUP]    = changed[1] && !header_byte[1];
    pkt.ev_mask[mpct_pkg::EVB_RCLICK] = changed[1] && !header_byte[1];
  end

  // Packets with nothing to report are dropped here
  assign push = last_byte && (pkt.ev_mask != '0);

  // Byte phase sequencing
  always_comb begin
    phase_next = phase;
    if (take_byte) begin
      unique case (phase)
        mpct_pkg::PH_XBYTE: phase_next = mpct_pkg::PH_YBYTE;
        mpct_pkg::PH_YBYTE: phase_next = mpct_pkg::PH_HEADER;
        default:            phase_next = mpct_pkg::PH_XBYTE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mpct_pkg::PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  // Packet bytes, cursor and button state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= '0;
      x_move_byte <= '0;
      cursor_x    <= mpct_pkg::CURSOR_X_RST;
      cursor_y    <= mpct_pkg::CURSOR_Y_RST;
      buttons_now <= '0;
    end else if (accept) begin
      if (mouse.func == mpct_pkg::FUNC_SET_POS) begin
        cursor_x <= mouse.new_x;
        cursor_y <= mouse.new_y;
      end else begin
        unique case (phase)
          mpct_pkg::PH_XBYTE: x_move_byte <= mouse.rx_byte;
          mpct_pkg::PH_YBYTE: begin
            cursor_x    <= pkt.pos_x;
            cursor_y    <= pkt.pos_y;
            buttons_now <= header_byte[2:0];
          end
          default: header_byte <= mouse.rx_byte;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/mpct_queue.sv -----
module mpct_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpct_pkg::pkt_t wr_pkt,
  input  logic           pop,
  output mpct_pkg::pkt_t head,
  output logic           full,
  output logic           empty
);

  mpct_pkg::pkt_t                entries [mpct_pkg::QDEPTH];
  logic [mpct_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mpct_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mpct_pkg::QPTR_W:0]     count;

  assign full  = (count == (mpct_pkg::QPTR_W+1)'(mpct_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_pkt;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/mpct_back.sv -----
module mpct_back (
  input  logic           clk,
  input  logic           rst,
  input  mpct_pkg::pkt_t head,
  input  logic           empty,
  output logic           pop,
  mpct_out_if.source     events
);

  logic [mpct_pkg::EV_N-1:0]     sent;
  logic [mpct_pkg::EV_N-1:0]     rem;
  logic [mpct_pkg::EV_N-1:0]     low;
  logic [mpct_pkg::EV_N-1:0]     rem_after;
  logic [mpct_pkg::EV_IDX_W-1:0] idx;
  logic                          load;
  logic                          is_last;

  // Next pending event of the head packet, lowest bit first
  assign rem       = head.ev_mask & ~sent;
  assign low       = rem & (~rem + 1'b1);
  assign rem_after = rem & ~low;
  assign is_last   = (rem_after == '0);

  always_comb begin
    idx = '0;
    for (int i = 0; i < mpct_pkg::EV_N; i++) begin
      if (low[i]) idx = mpct_pkg::EV_IDX_W'(i);
    end
  end

  assign load = !empty && (!events.valid || events.ready);
  assign pop  = load && is_last;

  // Progress through the head packet
  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (load) begin
      sent <= is_last ? '0 : (sent | low);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
    end else if (load) begin
      events.valid <= 1'b1;
    end else if (events.ready) begin
      events.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      events.event_kind   <= mpct_pkg::ev_kind(idx);
      events.which_button <= mpct_pkg::ev_button(idx);
      events.pos_x        <= head.pos_x;
      events.pos_y        <= head.pos_y;
      events.button_bits  <= head.buttons;
      events.last         <= is_last;
    end
  end

endmodule

// ----- rtl/core/mouse_packet_cursor_tracker_top.sv -----
// Channel   Dir  Transaction
// mouse     in   one mouse byte (func 0) or a cursor position write (func 1)
// events    out  one event: kind, clamped position, button, button bits, last
// cfg       in   write of width_limit (index 0) or height_limit (index 1)
//
// An input transaction is taken every cycle while the 4-entry packet queue has room.
// The third byte of a packet decodes, moves and clamps the cursor in that same cycle.
// The event unit sends one event per cycle while events is not stalled, 1 to 5 per
// packet; a packet is 3 input bytes, and its events overlap the next one.
// Reset is synchronous; rst restores phase, cursor (160,100), buttons and bounds.
// A stall on events backs up the queue; mouse.ready drops only when it is full.
module mouse_packet_cursor_tracker_top (
  input  logic                           clk,
  input  logic                           rst,
  mpct_in_if.sink                        mouse,
  mpct_out_if.source                     events,
  input  logic                           cfg_we,
  input  logic [mpct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpct_pkg::LIM_W-1:0]     cfg_data
);

  logic [mpct_pkg::LIM_W-1:0] width_limit;
  logic [mpct_pkg::LIM_W-1:0] height_limit;
  mpct_pkg::pkt_t             pkt;
  mpct_pkg::pkt_t             head;
  logic                       push;
  logic                       pop;
  logic                       q_full;
  logic                       q_empty;

  // Bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_limit  <= mpct_pkg::WIDTH_RST;
      height_limit <= mpct_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpct_pkg::CFG_WIDTH_LIMIT:  width_limit  <= cfg_data;
        mpct_pkg::CFG_HEIGHT_LIMIT: height_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  mpct_front u_front (
    .clk          (clk),
    .rst          (rst),
    .mouse        (mouse),
    .width_limit  (width_limit),
    .height_limit (height_limit),
    .q_full       (q_full),
    .push         (push),
    .pkt          (pkt)
  );

  mpct_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_pkt (pkt),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  mpct_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .events (events)
  );

  // Only packets that report something are queued
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (pkt.ev_mask != '0))
    else $error("queued packet carries no event");

  // The queue is never pushed while full nor popped while empty
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full packet queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty packet queue");

  // Popping a packet puts its final event in the output register
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (events.valid && events.last))
    else $error("packet retired without a final event");

endmodule

// ----- tb/mouse_packet_cursor_tracker_top_test.sv -----
`timescale 1ns / 1ps

module mouse_packet_cursor_tracker_top_test;

  localparam int IDLE_LIMIT  = 3000;  // cycles with no transaction before giving up
  localparam int DRAIN_SLACK = 20;    // settle time after the last event of a phase
  localparam int HOLD_SPAN   = 300;   // long receiver hold-off
  localparam int PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 16;

  // One event as seen on the output channel
  typedef struct {
    mpct_pkg::ev_kind_t            kind;
    logic [mpct_pkg::POS_BITS-1:0] x;
    logic [mpct_pkg::POS_BITS-1:0] y;
    mpct_pkg::btn_t                button;
    logic [2:0]                    bits;
    logic                          last;
  } ev_rec_t;

  // Tracks packet assembly and the cursor, and holds the events still owed
  class mouse_event_ledger;
    mpct_pkg::phase_t              byte_phase;
    logic [7:0]                    header_byte;
    logic [7:0]                    x_byte;
    logic [mpct_pkg::POS_BITS-1:0] cur_x;
    logic [mpct_pkg::POS_BITS-1:0] cur_y;
    logic [2:0]                    buttons;
    logic [mpct_pkg::LIM_W-1:0]    width_lim;
    logic [mpct_pkg::LIM_W-1:0]    height_lim;
    ev_rec_t                       owed_events[$];
    int                            errors;
    int                            events_checked;
    int                            items_taken;

    function new();
      byte_phase     = mpct_pkg::PH_HEADER;
      header_byte    = '0;
      x_byte         = '0;
      cur_x          = mpct_pkg::CURSOR_X_RST;
      cur_y          = mpct_pkg::CURSOR_Y_RST;
      buttons        = '0;
      width_lim      = mpct_pkg::WIDTH_RST;
      height_lim     = mpct_pkg::HEIGHT_RST;
      errors         = 0;
      events_checked = 0;
      items_taken    = 0;
    endfunction

    function void set_bound(logic [mpct_pkg::CFG_IDX_W-1:0] idx,
                            logic [mpct_pkg::LIM_W-1:0] value);
      if (idx == mpct_pkg::CFG_WIDTH_LIMIT) begin
        width_lim = value;
      end else begin
        height_lim = value;
      end
    endfunction

    // Zero bound acts as one; bound saturates at the coordinate range
    function int clamp_to_bound(int v, int bound);
      int top;
      if (bound == 0) bound = 1;
      if (bound > 2**mpct_pkg::POS_BITS) bound = 2**mpct_pkg::POS_BITS;
      top = bound - 1;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
    endfunction

    function ev_rec_t make_event(mpct_pkg::ev_kind_t k, mpct_pkg::btn_t b);
      ev_rec_t e;
      e.kind   = k;
      e.x      = cur_x;
      e.y      = cur_y;
      e.button = b;
      e.bits   = buttons;
      e.last   = 1'b0;
      return e;
    endfunction

    // Note one accepted input transaction and queue the events it causes
    function void take_item(logic f, logic [7:0] rb, logic [mpct_pkg::POS_BITS-1:0] nx,
                            logic [mpct_pkg::POS_BITS-1:0] ny);
      int             dx;
      int             dy;
      logic [2:0]     prev;
      logic [2:0]     flipped;
      mpct_pkg::btn_t btn;
      ev_rec_t        run[$];
      items_taken++;
      if (f == mpct_pkg::FUNC_SET_POS) begin
        // stored unclamped, packet phase untouched
        cur_x = nx;
        cur_y = ny;
        return;
      end
      case (byte_phase)
        mpct_pkg::PH_XBYTE: begin
          x_byte     = rb;
          byte_phase = mpct_pkg::PH_YBYTE;
          return;
        end
        mpct_pkg::PH_YBYTE: ;
        default: begin
          header_byte = rb;
          byte_phase  = mpct_pkg::PH_XBYTE;
          return;
        end
      endcase

      // Y byte: decode 9-bit deltas from the header sign bits
      byte_phase = mpct_pkg::PH_HEADER;
      prev       = buttons;
      buttons    = header_byte[2:0];
      dx = header_byte[mpct_pkg::HDR_X_SIGN] ? int'(x_byte) - 256 : int'(x_byte);
      dy = header_byte[mpct_pkg::HDR_Y_SIGN] ? int'(rb) - 256 : int'(rb);
      cur_x = mpct_pkg::POS_BITS'(clamp_to_bound(int'(cur_x) + dx, int'(width_lim)));
      cur_y = mpct_pkg::POS_BITS'(clamp_to_bound(int'(cur_y) - dy, int'(height_lim)));

      if (dx != 0 || dy != 0) run.push_back(make_event(mpct_pkg::EV_MOVE, mpct_pkg::BTN_NONE));
      flipped = buttons ^ prev;
      for (int b = 0; b < 2; b++) begin
        btn = (b == 0) ? mpct_pkg::BTN_LEFT : mpct_pkg::BTN_RIGHT;
        if (flipped[b]) begin
          if (buttons[b]) begin
            run.push_back(make_event(mpct_pkg::EV_DOWN, btn));
          end else begin
            run.push_back(make_event(mpct_pkg::EV_UP, btn));
            run.push_back(make_event(mpct_pkg::EV_CLICK, btn));
          end
        end
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) owed_events.push_back(run[i]);
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Compare one output transaction with the oldest owed event
    task check_event(ev_rec_t got);
      ev_rec_t want;
      events_checked++;
      if (owed_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event %s at (%0d,%0d)",
                                got.kind.name(), got.x, got.y));
        return;
      end
      want = owed_events.pop_front();
      if (got.kind !== want.kind)
        flag_mismatch($sformatf("event %0d kind %0d, want %0d",
                                events_checked, got.kind, want.kind));
      if (got.x !== want.x)
        flag_mismatch($sformatf("event %0d pos_x %0d, want %0d",
                                events_checked, got.x, want.x));
      if (got.y !== want.y)
        flag_mismatch($sformatf("event %0d pos_y %0d, want %0d",
                                events_checked, got.y, want.y));
      if (got.button !== want.button)
        flag_mismatch($sformatf("event %0d which_button %0d, want %0d",
                                events_checked, got.button, want.button));
      if (got.bits !== want.bits)
        flag_mismatch($sformatf("event %0d button_bits %b, want %b",
                                events_checked, got.bits, want.bits));
      if (got.last !== want.last)
        flag_mismatch($sformatf("event %0d last %b, want %b",
                                events_checked, got.last, want.last));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [mpct_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mpct_pkg::LIM_W-1:0]     cfg_data;

  mpct_in_if  mouse_ch();
  mpct_out_if event_ch();

  mouse_event_ledger ledger;
  bit tx_idle_on;
  bit rx_idle_on;
  int hold_span;
  int idle_cycles;

  mouse_packet_cursor_tracker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .mouse     (mouse_ch),
    .events    (event_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output monitor
  always @(posedge clk) begin
    ev_rec_t got;
    if (!rst && event_ch.valid && event_ch.ready) begin
      got.kind   = mpct_pkg::ev_kind_t'(event_ch.event_kind);
      got.x      = event_ch.pos_x;
      got.y      = event_ch.pos_y;
      got.button = mpct_pkg::btn_t'(event_ch.which_button);
      got.bits   = event_ch.button_bits;
      got.last   = event_ch.last;
      ledger.check_event(got);
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (mouse_ch.valid && mouse_ch.ready) ||
        (event_ch.valid && event_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Event receiver: random stalls, or one long hold-off when requested
  initial begin
    int span;
    wait (rst === 1'b0);
    forever begin
      if (hold_span > 0) begin
        span      = hold_span;
        hold_span = 0;
      end else begin
        span = rx_idle_on ? $urandom_range(0, 15) : 0;
      end
      @(negedge clk);
      if (span > 0) begin
        event_ch.ready = 1'b0;
        repeat (span) @(negedge clk);
      end
      event_ch.ready = 1'b1;
      do @(posedge clk); while (!event_ch.valid);
    end
  end

  // Offer one input transaction; entered and left at a falling edge
  task automatic send_item(input logic f, input logic [7:0] rb,
                           input logic [mpct_pkg::POS_BITS-1:0] nx,
                           input logic [mpct_pkg::POS_BITS-1:0] ny);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      mouse_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mouse_ch.func    = f;
    mouse_ch.rx_byte = rb;
    mouse_ch.new_x   = nx;
    mouse_ch.new_y   = ny;
    mouse_ch.valid   = 1'b1;
    do @(posedge clk); while (!mouse_ch.ready);
    ledger.take_item(f, rb, nx, ny);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] rb);
    send_item(mpct_pkg::FUNC_RX_BYTE, rb, mpct_pkg::POS_BITS'($urandom),
              mpct_pkg::POS_BITS'($urandom));
  endtask

  task automatic send_pos(input logic [mpct_pkg::POS_BITS-1:0] nx,
                          input logic [mpct_pkg::POS_BITS-1:0] ny);
    send_item(mpct_pkg::FUNC_SET_POS, 8'($urandom), nx, ny);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Delta byte: zero, tiny either way, or anything
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'($urandom_range(0, 3));
      2:       return 8'(8'hFF - $urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Write both bounds; only while the block is idle
  task automatic settle_bounds(input logic [mpct_pkg::LIM_W-1:0] w,
                               input logic [mpct_pkg::LIM_W-1:0] h);
    cfg_we    = 1'b1;
    cfg_index = mpct_pkg::CFG_WIDTH_LIMIT;
    cfg_data  = w;
    @(negedge clk);
    cfg_index = mpct_pkg::CFG_HEIGHT_LIMIT;
    cfg_data  = h;
    @(negedge clk);
    cfg_we = 1'b0;
    ledger.set_bound(mpct_pkg::CFG_WIDTH_LIMIT, w);
    ledger.set_bound(mpct_pkg::CFG_HEIGHT_LIMIT, h);
  endtask

  // Stop offering and wait for every owed event, then let the block settle
  task automatic quiesce();
    mouse_ch.valid = 1'b0;
    while (ledger.owed_events.size() > 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // Mostly whole packets, some cursor writes and stray bytes
  task automatic random_traffic(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        // finish a packet broken by a stray byte before starting a new one
        while (ledger.byte_phase != mpct_pkg::PH_HEADER) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
        send_packet(8'($urandom_range(0, 255)), pick_delta(), pick_delta());
        sent += 3;
      end else if (pick < 17) begin
        send_pos(mpct_pkg::POS_BITS'($urandom_range(0, 2**mpct_pkg::POS_BITS - 1)),
                 mpct_pkg::POS_BITS'($urandom_range(0, 2**mpct_pkg::POS_BITS - 1)));
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  task automatic directed_items();
    send_packet(8'h08, 8'h00, 8'h00);  // bit 3 only: no delta, no change
    send_packet(8'h09, 8'h05, 8'h03);  // move plus left down
    send_packet(8'h32, 8'h00, 8'h01);  // most negative dx, left up/click, right down
    send_packet(8'hC4, 8'hFF, 8'hFF);  // overflow bits ignored, largest positive deltas
    send_pos(14'h3FFF, 14'h3FFF);      // far outside the bounds, stored as is
    send_packet(8'h03, 8'h00, 8'h00);  // both down, no move, cursor clamps
    // cursor write in the middle of a packet, then the five-event run
    send_byte(8'h34);
    send_byte(8'hFF);
    send_pos(14'h0000, 14'h0000);
    send_byte(8'hFF);
    send_packet(8'h00, 8'h00, 8'h00);  // middle release alone: no event
  endtask

  initial begin
    logic [mpct_pkg::LIM_W-1:0] w_set[PHASES];
    logic [mpct_pkg::LIM_W-1:0] h_set[PHASES];
    ledger = new();
    w_set = '{15'd320, 15'd1, 15'd16384, 15'd0, 15'h7FFF, 15'd0};
    h_set = '{15'd200, 15'd1, 15'd16384, 15'd0, 15'd16385, 15'd0};
    w_set[PHASES-1] = mpct_pkg::LIM_W'($urandom_range(2, 16383));
    h_set[PHASES-1] = mpct_pkg::LIM_W'($urandom_range(2, 16383));

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = mpct_pkg::CFG_WIDTH_LIMIT;
    cfg_data          = '0;
    mouse_ch.valid    = 1'b0;
    mouse_ch.func     = mpct_pkg::FUNC_RX_BYTE;
    mouse_ch.rx_byte  = '0;
    mouse_ch.new_x    = '0;
    mouse_ch.new_y    = '0;
    event_ch.ready    = 1'b0;
    tx_idle_on        = 1'b1;
    rx_idle_on        = 1'b1;
    hold_span         = 0;
    idle_cycles       = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset bounds first
    directed_items();
    quiesce();

    for (int p = 0; p < PHASES; p++) begin
      tx_idle_on = (p % 3 != 1);
      rx_idle_on = (p % 3 == 0);
      settle_bounds(w_set[p], h_set[p]);
      if (p == 2) begin
        // long receiver stall with the sender pushing back-to-back packets
        tx_idle_on = 1'b0;
        hold_span  = HOLD_SPAN;
        repeat (10) send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                                8'($urandom_range(1, 255)));
        tx_idle_on = 1'b1;
      end
      random_traffic(ITEMS_PER_PHASE);
      quiesce();
    end

    if (ledger.owed_events.size() != 0)
      ledger.flag_mismatch($sformatf("%0d events never arrived",
                                     ledger.owed_events.size()));
    $display("Covered %0d mouse transactions and %0d events over %0d bound settings",
             ledger.items_taken, ledger.events_checked, PHASES + 1);
    $display("incl. zero, one, full-range and out-of-range bounds and a long output stall");
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mpct_pkg.sv
rtl/core/mpct_in_if.sv
rtl/core/mpct_out_if.sv
rtl/core/mpct_front.sv
rtl/core/mpct_queue.sv
rtl/core/mpct_back.sv
rtl/core/mouse_packet_cursor_tracker_top.sv
tb/mouse_packet_cursor_tracker_top_test.sv
